[hdl/dfns_pkg.sv]
// Shared types, constants and saturating helpers for the coupled Newton square root.
package dfns_pkg;

   localparam int MAX_ITERATIONS_DEFAULT = 8;
   localparam logic [3:0] ITERATION_RESET = 4'd3;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_ZERO = 2'd1;
   localparam logic [1:0] STATUS_SAT  = 2'd2;

   localparam logic [63:0] Q_ONE = 64'h0000_0001_0000_0000;
   localparam logic [63:0] S_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] S_MIN = 64'h8000_0000_0000_0000;

   // Seed reciprocal floor(2^47 / a): 48 quotient bits, a few per stage.
   localparam int DIV_BITS      = 48;
   localparam int DIV_PER_STAGE = 4;
   localparam int DIV_STAGES    = DIV_BITS / DIV_PER_STAGE;

   localparam int QMUL_LATENCY = 4;
   localparam int ROUND_LATENCY = 3 * QMUL_LATENCY + 2;

   typedef struct packed {
      logic        zero;
      logic        sat;
      logic [3:0]  rounds;
      logic [31:0] operand;
      logic [63:0] x;
      logic [63:0] y;
   } item_type;

   typedef struct packed {
      logic        sat;
      logic [63:0] value;
   } sat_result_type;

   function automatic sat_result_type sat_add(input logic [63:0] a, input logic [63:0] b);
      sat_result_type res;
      logic [63:0] r;
      r = a + b;
      res.sat = 1'b0;
      res.value = r;
      if ((a[63] == b[63]) && (r[63] != a[63])) begin
         res.sat = 1'b1;
         res.value = a[63] ? S_MIN : S_MAX;
      end
      return res;
   endfunction

   function automatic sat_result_type sat_sub(input logic [63:0] a, input logic [63:0] b);
      sat_result_type res;
      logic [63:0] r;
      r = a - b;
      res.sat = 1'b0;
      res.value = r;
      if ((a[63] != b[63]) && (r[63] != a[63])) begin
         res.sat = 1'b1;
         res.value = a[63] ? S_MIN : S_MAX;
      end
      return res;
   endfunction

endpackage

[hdl/division_free_newton_sqrt.sv]
// Top level of the pipelined coupled Newton square root.
//
// Square root of an unsigned Q16.16 operand by a coupled Newton iteration
// in signed Q32.32: seed x0 = operand/2 and y0 = floor(2^47/operand), then
// iteration_count rounds (clamped to MAX_ITERATIONS) of y = 2y(1-xy) and
// x = x - (x*x-operand)*y. A zero operand returns 0 with status 1; any
// saturation, a negative result or one beyond the Q16.16 range gives
// status 2. The block takes one operand per cycle while the skid entry is
// free and returns one result per operand in order. The pipe holds 12
// divider stages for the seed (four quotient bits each), 14 stages per
// unrolled round (three dependent four-stage multipliers plus two add
// stages), and the output register. Every round is built regardless of
// the configured count; shorter counts pass through the unused rounds. A
// one-entry skid behind the output register takes one more result when
// the sink stalls, and the pipe stops while the skid is full.
// Write iteration_count only while no transaction is in flight.
module division_free_newton_sqrt #(
   parameter int MAX_ITERATIONS = dfns_pkg::MAX_ITERATIONS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] operand
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] root, [33:32] status, [39:34] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data     // iteration_count
);

   logic [3:0] iter_ff;
   logic       en;

   dfns_pkg::item_type entry;
   dfns_pkg::item_type chain_item  [MAX_ITERATIONS+1];
   logic               chain_valid [MAX_ITERATIONS+1];
   dfns_pkg::item_type last_item;

   logic [31:0] root_in, root_ff, skid_root_ff;
   logic [1:0]  status_in, status_ff, skid_status_ff;
   logic        rsp_valid_ff, skid_valid_ff;

   // configuration
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= dfns_pkg::ITERATION_RESET;
      end else if (csr_valid) begin
         iter_ff <= csr_data;
      end
   end

   // whole pipe advances while the skid entry is free
   assign en         = ~skid_valid_ff;
   assign req_tready = en;

   always_comb begin
      entry.zero    = (req_tdata == 32'd0);
      entry.sat     = 1'b0;
      entry.rounds  = (32'(iter_ff) > MAX_ITERATIONS) ? 4'(MAX_ITERATIONS) : iter_ff;
      entry.operand = req_tdata;
      entry.x       = {17'd0, req_tdata, 15'd0};
      entry.y       = 64'd0;
   end

   dfns_divider u_divider (
      .clock, .reset, .en,
      .in_valid (req_tvalid & en),
      .in_item  (entry),
      .out_valid(chain_valid[0]),
      .out_item (chain_item[0])
   );

   for (genvar i = 0; i < MAX_ITERATIONS; i++) begin : g_round
      dfns_round #(.INDEX(i)) u_round (
         .clock, .reset, .en,
         .in_valid (chain_valid[i]),
         .in_item  (chain_item[i]),
         .out_valid(chain_valid[i+1]),
         .out_item (chain_item[i+1])
      );
   end

   assign last_item = chain_item[MAX_ITERATIONS];

   // result formatting
   always_comb begin
      if (last_item.zero) begin
         root_in   = 32'd0;
         status_in = dfns_pkg::STATUS_ZERO;
      end else if (last_item.x[63]) begin
         root_in   = 32'd0;
         status_in = dfns_pkg::STATUS_SAT;
      end else if (|last_item.x[62:48]) begin
         root_in   = 32'hFFFF_FFFF;
         status_in = dfns_pkg::STATUS_SAT;
      end else begin
         root_in   = last_item.x[47:16];
         status_in = last_item.sat ? dfns_pkg::STATUS_SAT : dfns_pkg::STATUS_OK;
      end
   end

   // output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (en) begin
         if (~rsp_valid_ff | rsp_tready) begin
            rsp_valid_ff <= chain_valid[MAX_ITERATIONS];
         end else if (chain_valid[MAX_ITERATIONS]) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_tready) begin
         rsp_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (~rsp_valid_ff | rsp_tready) begin
            root_ff   <= root_in;
            status_ff <= status_in;
         end else begin
            skid_root_ff   <= root_in;
            skid_status_ff <= status_in;
         end
      end else if (rsp_tready) begin
         root_ff   <= skid_root_ff;
         status_ff <= skid_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, status_ff, root_ff};

endmodule

[hdl/dfns_delay.sv]
// Stallable shift line of fixed depth.
module dfns_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] stage_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            stage_ff[i] <= stage_ff[i-1];
         end
      end
   end

   assign q = stage_ff[DEPTH-1];

endmodule

[hdl/dfns_qmul.sv]
// Four-stage signed Q32.32 multiplier, truncating and saturating.
module dfns_qmul (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] p,
   output logic        sat
);

   logic [63:0]  ma_ff, mb_ff;
   logic         neg1_ff, neg2_ff, neg3_ff;
   logic [63:0]  p00_ff, p01_ff, p10_ff, p11_ff;
   logic [127:0] mag_ff;
   logic [63:0]  p_ff;
   logic         sat_ff;
   logic [127:0] signed_w;
   logic         fits_w;

   // magnitude, then signed and range check
   assign signed_w = neg3_ff ? (~mag_ff + 128'd1) : mag_ff;
   assign fits_w   = (&signed_w[127:95]) | ~(|signed_w[127:95]);

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff   <= a[63] ? (~a + 64'd1) : a;
         mb_ff   <= b[63] ? (~b + 64'd1) : b;
         neg1_ff <= a[63] ^ b[63];

         p00_ff  <= ma_ff[31:0]  * mb_ff[31:0];
         p01_ff  <= ma_ff[31:0]  * mb_ff[63:32];
         p10_ff  <= ma_ff[63:32] * mb_ff[31:0];
         p11_ff  <= ma_ff[63:32] * mb_ff[63:32];
         neg2_ff <= neg1_ff;

         mag_ff  <= {p11_ff, 64'd0} + {32'd0, p01_ff, 32'd0}
                  + {32'd0, p10_ff, 32'd0} + {64'd0, p00_ff};
         neg3_ff <= neg2_ff;

         sat_ff  <= ~fits_w;
         p_ff    <= fits_w ? signed_w[95:32]
                           : (signed_w[127] ? dfns_pkg::S_MIN : dfns_pkg::S_MAX);
      end
   end

   assign p   = p_ff;
   assign sat = sat_ff;

endmodule

[hdl/dfns_divider.sv]
// Pipelined restoring divider forming the seed y0 = floor(2^47 / operand).
module dfns_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  dfns_pkg::item_type in_item,
   output logic               out_valid,
   output dfns_pkg::item_type out_item
);

   localparam int S = dfns_pkg::DIV_STAGES;

   logic [31:0]        r_ff    [S];
   logic [47:0]        q_ff    [S];
   dfns_pkg::item_type item_ff [S];
   logic [S-1:0]       valid_ff;

   for (genvar s = 0; s < S; s++) begin : g_stage
      logic [31:0]        r_src;
      logic [47:0]        q_src;
      dfns_pkg::item_type item_src;
      logic [31:0]        r_nxt;
      logic [47:0]        q_nxt;

      if (s == 0) begin : g_first
         assign r_src    = 32'd0;
         assign q_src    = 48'd0;
         assign item_src = in_item;
      end else begin : g_next
         assign r_src    = r_ff[s-1];
         assign q_src    = q_ff[s-1];
         assign item_src = item_ff[s-1];
      end

      always_comb begin
         logic [32:0] sh;
         logic [31:0] r;
         logic [47:0] q;
         r = r_src;
         q = q_src;
         for (int j = 0; j < dfns_pkg::DIV_PER_STAGE; j++) begin
            // dividend 2^47: only its first bit is set
            sh = {r, ((s == 0) && (j == 0)) ? 1'b1 : 1'b0};
            if (sh >= {1'b0, item_src.operand}) begin
               sh = sh - {1'b0, item_src.operand};
               q  = {q[46:0], 1'b1};
            end else begin
               q  = {q[46:0], 1'b0};
            end
            r = sh[31:0];
         end
         r_nxt = r;
         q_nxt = q;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[s]    <= r_nxt;
            q_ff[s]    <= q_nxt;
            item_ff[s] <= item_src;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[S-2:0], in_valid};
      end
   end

   always_comb begin
      out_item   = item_ff[S-1];
      out_item.y = {16'd0, q_ff[S-1]};
   end

   assign out_valid = valid_ff[S-1];

endmodule

[hdl/dfns_round.sv]
// One coupled Newton round: y = 2y(1-xy), then x = x - (x*x-operand)*y.
module dfns_round #(
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  dfns_pkg::item_type in_item,
   output logic               out_valid,
   output dfns_pkg::item_type out_item
);

   localparam int L  = dfns_pkg::QMUL_LATENCY;
   localparam int LR = dfns_pkg::ROUND_LATENCY;
   localparam int W  = $bits(dfns_pkg::item_type);

   logic [63:0] pa, pc, pb, pd;
   logic        sat_a, sat_c, sat_b, sat_d;
   dfns_pkg::item_type item4, item5_in, item5_ff, item9, item9b, item13, orig13;
   dfns_pkg::item_type out_in, out_ff;
   logic [63:0] t_ff, y2_ff, d_ff, d9;
   logic [LR-1:0] valid_ff;
   dfns_pkg::sat_result_type t_w, y2_w, d_w, x_w;

   dfns_qmul u_mul_xy (.clock, .en, .a(in_item.x), .b(in_item.y), .p(pa), .sat(sat_a));
   dfns_qmul u_mul_xx (.clock, .en, .a(in_item.x), .b(in_item.x), .p(pc), .sat(sat_c));

   dfns_delay #(.WIDTH(W), .DEPTH(L)) u_dly_item4 (.clock, .en, .d(in_item), .q(item4));

   assign t_w  = dfns_pkg::sat_sub(dfns_pkg::Q_ONE, pa);
   assign y2_w = dfns_pkg::sat_add(item4.y, item4.y);
   assign d_w  = dfns_pkg::sat_sub(pc, {16'd0, item4.operand, 16'd0});

   always_comb begin
      item5_in     = item4;
      item5_in.sat = item4.sat | sat_a | sat_c | t_w.sat | y2_w.sat | d_w.sat;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff     <= t_w.value;
         y2_ff    <= y2_w.value;
         d_ff     <= d_w.value;
         item5_ff <= item5_in;
      end
   end

   dfns_qmul u_mul_y (.clock, .en, .a(y2_ff), .b(t_ff), .p(pb), .sat(sat_b));
   dfns_delay #(.WIDTH(W), .DEPTH(L)) u_dly_item9 (.clock, .en, .d(item5_ff), .q(item9));
   dfns_delay #(.WIDTH(64), .DEPTH(L)) u_dly_d9 (.clock, .en, .d(d_ff), .q(d9));

   always_comb begin
      item9b     = item9;
      item9b.y   = pb;
      item9b.sat = item9.sat | sat_b;
   end

   dfns_qmul u_mul_x (.clock, .en, .a(d9), .b(pb), .p(pd), .sat(sat_d));
   dfns_delay #(.WIDTH(W), .DEPTH(L)) u_dly_item13 (.clock, .en, .d(item9b), .q(item13));
   dfns_delay #(.WIDTH(W), .DEPTH(LR-1)) u_dly_orig (.clock, .en, .d(in_item), .q(orig13));

   assign x_w = dfns_pkg::sat_sub(item13.x, pd);

   // rounds beyond the item's count pass it through unchanged
   always_comb begin
      if (32'(orig13.rounds) > INDEX) begin
         out_in     = item13;
         out_in.x   = x_w.value;
         out_in.sat = item13.sat | sat_d | x_w.sat;
      end else begin
         out_in     = orig13;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LR-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[LR-1];
   assign out_item  = out_ff;

endmodule

[test/division_free_newton_sqrt_checker.sv]
// Checker for the coupled Newton square root: predicts each root and compares it.
`timescale 1ns / 100ps
module division_free_newton_sqrt_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [3:0]  csr_data,
   output int          fail_count,
   output int          pending_count
);

   localparam int MAX_ROUNDS = dfns_pkg::MAX_ITERATIONS_DEFAULT;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] root;
   } root_type;

   root_type   expected_roots[$];
   logic [3:0] round_setting;
   logic       sat_flag;

   function automatic logic [63:0] add_s(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] r;
      r = a + b;
      if (a[63] == b[63] && r[63] != a[63]) begin
         sat_flag = 1'b1;
         r = a[63] ? dfns_pkg::S_MIN : dfns_pkg::S_MAX;
      end
      return r;
   endfunction

   function automatic logic [63:0] sub_s(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] r;
      r = a - b;
      if (a[63] != b[63] && r[63] != a[63]) begin
         sat_flag = 1'b1;
         r = a[63] ? dfns_pkg::S_MIN : dfns_pkg::S_MAX;
      end
      return r;
   endfunction

   // Full 128-bit signed product, arithmetic shift of 32, clamp to 64 bits.
   function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
      logic signed [127:0] p;
      logic signed [127:0] s;
      p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
      s = p >>> 32;
      if (s > $signed({64'd0, dfns_pkg::S_MAX})) begin
         sat_flag = 1'b1;
         return dfns_pkg::S_MAX;
      end
      if (s < $signed({{64{1'b1}}, dfns_pkg::S_MIN})) begin
         sat_flag = 1'b1;
         return dfns_pkg::S_MIN;
      end
      return s[63:0];
   endfunction

   function automatic root_type predict_root(input logic [31:0] a, input logic [3:0] cnt);
      root_type    res;
      logic [63:0] big, x, y, t;
      int          rounds;
      if (a == 0) begin
         res.root = '0;
         res.status = dfns_pkg::STATUS_ZERO;
         return res;
      end
      sat_flag = 1'b0;
      big = {16'd0, a, 16'd0};
      x = {17'd0, a, 15'd0};
      y = (64'd1 << 47) / {32'd0, a};
      rounds = (cnt > MAX_ROUNDS) ? MAX_ROUNDS : cnt;
      for (int i = 0; i < rounds; i++) begin
         t = sub_s(dfns_pkg::Q_ONE, mul_q(x, y));
         y = mul_q(add_s(y, y), t);
         x = sub_s(x, mul_q(sub_s(mul_q(x, x), big), y));
      end
      if (x[63]) begin
         res.root = '0;
         res.status = dfns_pkg::STATUS_SAT;
      end else if (x >= (64'd1 << 48)) begin
         res.root = '1;
         res.status = dfns_pkg::STATUS_SAT;
      end else begin
         res.root = x[47:16];
         res.status = sat_flag ? dfns_pkg::STATUS_SAT : dfns_pkg::STATUS_OK;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [39:0] got,
                                  input logic [39:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   always @(posedge clock) begin
      root_type want;
      if (reset) begin
         round_setting <= dfns_pkg::ITERATION_RESET;
         expected_roots.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) round_setting <= csr_data;
         if (req_tvalid && req_tready)
            expected_roots.push_back(predict_root(req_tdata, round_setting));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_roots.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_tdata, '0);
            end else begin
               want = expected_roots.pop_front();
               if (rsp_tdata[31:0] !== want.root)
                  report_mismatch("root", rsp_tdata, {6'd0, want});
               if (rsp_tdata[33:32] !== want.status)
                  report_mismatch("status", rsp_tdata, {6'd0, want});
            end
         end
      end
      pending_count = expected_roots.size();
   end
endmodule

[test/division_free_newton_sqrt_tb.sv]
// Testbench top: drives operands and round counts into the square root and gives the verdict.
`timescale 1ns / 100ps
module division_free_newton_sqrt_tb;

   // depth of the pipe through the divider, every round and the output register
   localparam int LATENCY   = 13 + 14 * dfns_pkg::MAX_ITERATIONS_DEFAULT;
   localparam int WATCHDOG  = 20 * LATENCY;
   localparam int RANDOM_N  = 1900;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_data = '0;
   int          fail_count;
   int          pending_count;
   int          idle_cycles;
   logic        sink_run = 1'b0;

   always #5 clock = ~clock;

   division_free_newton_sqrt u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   division_free_newton_sqrt_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // Watchdog: any cycle without a transaction counts toward the limit.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("watchdog expired");
         $display("== FAIL ==");
         $finish;
      end
   end

   // The sink stalls at random before each result, or not at all.
   always begin
      int gap;
      @(negedge clock);
      if (!sink_run) begin
         rsp_tready <= 1'b0;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Valid stays high after a transaction; a gapped call, a drain or a hold-off drops it.
   task automatic send_operand(input logic [31:0] value, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= value;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drain everything outstanding, then let the pipe go quiet before a write.
   task automatic drain_pipe;
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_rounds(input logic [3:0] value);
      drain_pipe();
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly modest operands, with full range and bit-walk mixed in.
   function automatic logic [31:0] random_operand;
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 255);
         2: return 32'd1 << $urandom_range(0, 31);
         3: return $urandom_range(32'h0001_0000, 32'h0100_0000);
         4: return 32'hFFFF_FFFF - $urandom_range(0, 255);
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   initial begin
      logic [31:0] directed[$];
      logic [3:0]  round_plan[$];
      bit          burst;
      directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'h0000_8000, 32'h0001_0000,
                   32'h0004_0000, 32'h0002_0000, 32'h0010_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                   32'h0000_FFFF, 32'hFFFF_0000, 32'd0};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      sink_run <= 1'b1;

      // reset round count of three first
      foreach (directed[i]) send_operand(directed[i], 1'b0);
      // zero rounds returns the seed; above the maximum clamps
      round_plan = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd9};
      foreach (round_plan[k]) begin
         write_rounds(round_plan[k]);
         foreach (directed[i]) send_operand(directed[i], 1'b1);
      end

      round_plan = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd15, 4'd0};
      foreach (round_plan[k]) begin
         write_rounds(round_plan[k]);
         for (int n = 0; n < RANDOM_N / 10; n++) begin
            burst = (n % 60) < 20;
            send_operand(random_operand(), burst);
            // sender hold-off until the pipe is empty
            if (n == RANDOM_N / 20) begin
               req_tvalid <= 1'b0;
               while (pending_count != 0) @(negedge clock);
            end
         end
      end

      drain_pipe();
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

[filelist.f]
hdl/dfns_pkg.sv
hdl/dfns_delay.sv
hdl/dfns_qmul.sv
hdl/dfns_divider.sv
hdl/dfns_round.sv
hdl/division_free_newton_sqrt.sv
test/division_free_newton_sqrt_checker.sv
test/division_free_newton_sqrt_tb.sv
